### rtl/afd_pkg.sv
// Shared types and constants for the advert frame deframer.
package afd_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned AddrW  = 48;
  localparam int unsigned ByteW  = 8;

  localparam logic [PhaseW-1:0] PH_HUNT   = 3'd0;
  localparam logic [PhaseW-1:0] PH_GOT_A  = 3'd1;
  localparam logic [PhaseW-1:0] PH_GOT_AD = 3'd2;
  localparam logic [PhaseW-1:0] PH_ADDR   = 3'd3;
  localparam logic [PhaseW-1:0] PH_LEN    = 3'd4;
  localparam logic [PhaseW-1:0] PH_DATA   = 3'd5;

  localparam logic [ByteW-1:0] MARK_A = 8'h41;
  localparam logic [ByteW-1:0] MARK_D = 8'h44;
  localparam logic [ByteW-1:0] MARK_V = 8'h56;

  localparam logic [ByteW-1:0] ADDR_BYTES = 8'd6;

  typedef struct packed {
    logic [ByteW-1:0] byte_index;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] frame_length;
    logic [AddrW-1:0] device_address;
    logic             empty_frame;
    logic             last_of_frame;
  } afd_result_t;

endpackage

### rtl/advert_frame_deframer.sv
// Top level of the advert frame deframer: parser plus registered output with skid stage.
//
// Takes one byte per cycle whenever the output side is not stalled for two results.
// Each byte is parsed in the cycle it is accepted; a payload or empty-frame result
// is registered in the output register, or in the skid register while the output
// is stalled. s_axis_tready_o stays high until the skid register holds a result.
// Bytes before the marker "ADV" are dropped; marker and address bytes give no output
// transaction, and a length byte gives one only when it is zero (empty frame).
module advert_frame_deframer import afd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [47:0] device_address, [55:48] frame_length, [63:56] payload_byte,
  // [71:64] byte_index
  output logic [71:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // [0] empty_frame
  output logic        m_axis_tlast_o    // last_of_frame
);

  logic        accept;
  logic        res_valid;
  afd_result_t res;
  logic        out_vld_q, out_vld_d;
  afd_result_t out_q, out_d;
  logic        skid_vld_q, skid_vld_d;
  afd_result_t skid_q, skid_d;
  logic        out_free;

  assign s_axis_tready_o = !skid_vld_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  afd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .rx_byte_i   (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free = m_axis_tready_i || !out_vld_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (out_free) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = res_valid;
        out_d     = res;
      end
    end else if (res_valid) begin
      skid_vld_d = 1'b1;
      skid_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_q.byte_index, out_q.payload_byte,
                            out_q.frame_length, out_q.device_address};
  assign m_axis_tuser_o  = out_q.empty_frame;
  assign m_axis_tlast_o  = out_q.last_of_frame;

endmodule

### rtl/afd_parser.sv
// Frame header parser: marker hunt, address and length capture, payload tagging.
module afd_parser import afd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [ByteW-1:0]  rx_byte_i,
  output logic              res_valid_o,
  output afd_result_t       res_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [ByteW-1:0]  cnt_q, cnt_d;
  logic [ByteW-1:0]  len_q, len_d;
  logic [PhaseW-1:0] restart;
  logic [ByteW-1:0]  cnt_inc;
  logic              data_last;

  assign restart   = (rx_byte_i == MARK_A) ? PH_GOT_A : PH_HUNT;
  assign cnt_inc   = cnt_q + 8'd1;
  assign data_last = ({1'b0, cnt_q} + 9'd1) >= {1'b0, len_q};

  always_comb begin
    phase_d     = phase_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    res_valid_o = 1'b0;
    res_o.device_address = addr_q;
    res_o.frame_length   = len_q;
    res_o.payload_byte   = '0;
    res_o.byte_index     = '0;
    res_o.empty_frame    = 1'b0;
    res_o.last_of_frame  = 1'b0;
    unique case (phase_q)
      PH_GOT_A: begin
        phase_d = (rx_byte_i == MARK_D) ? PH_GOT_AD : restart;
      end
      PH_GOT_AD: begin
        if (rx_byte_i == MARK_V) begin
          phase_d = PH_ADDR;
          cnt_d   = '0;
          addr_d  = '0;
        end else begin
          phase_d = restart;
        end
      end
      PH_ADDR: begin
        addr_d = {addr_q[AddrW-ByteW-1:0], rx_byte_i};
        cnt_d  = cnt_inc;
        if (cnt_inc >= ADDR_BYTES) begin
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        len_d = rx_byte_i;
        cnt_d = '0;
        res_o.frame_length = rx_byte_i;
        if (rx_byte_i == '0) begin
          res_valid_o         = 1'b1;
          res_o.empty_frame   = 1'b1;
          res_o.last_of_frame = 1'b1;
          phase_d             = PH_HUNT;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        res_valid_o         = 1'b1;
        res_o.payload_byte  = rx_byte_i;
        res_o.byte_index    = cnt_q;
        res_o.last_of_frame = data_last;
        if (data_last) begin
          phase_d = PH_HUNT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
        phase_d = restart;
      end
    endcase
    if (!step_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      addr_q  <= '0;
      cnt_q   <= '0;
      len_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
    end
  end

endmodule
